FILE: hw/rtl/frame_bitmap_allocator_defines.svh
// Assertion helpers for the frame bitmap allocator
`ifndef FRAME_BITMAP_ALLOCATOR_DEFINES_SVH
`define FRAME_BITMAP_ALLOCATOR_DEFINES_SVH

`ifndef SYNTH
`define FBA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define FBA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define FBA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FBA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: hw/rtl/fba_pkg.sv
`timescale 1ns / 1ps
package fba_pkg;

  localparam int FRAME_W = 16;
  localparam int RUN_W   = 7;
  localparam int CNT_W   = 17;

  localparam logic [2:0] OP_MARK_USED = 3'd0;
  localparam logic [2:0] OP_MARK_FREE = 3'd1;
  localparam logic [2:0] OP_TEST      = 3'd2;
  localparam logic [2:0] OP_ALLOC_ONE = 3'd3;
  localparam logic [2:0] OP_ALLOC_RUN = 3'd4;

  localparam logic REG_FRAME_COUNT = 1'b0;

  typedef enum logic [2:0] {
    K_MARK_USED,
    K_MARK_FREE,
    K_TEST,
    K_ALLOC_ONE,
    K_ALLOC_RUN,
    K_NOP
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [FRAME_W-1:0] frame;
    logic [RUN_W-1:0]   run;
    logic               inr;
    logic               run_ok;
  } cmd_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               used;
    logic               failed;
  } res_t;

  typedef struct packed {
    logic clearing;
    logic pop;
  } back_stat_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BIT,
    ST_SCAN,
    ST_MARK_RD,
    ST_MARK_WR
  } state_t;

endpackage

FILE: hw/rtl/fba_front.sv
`timescale 1ns / 1ps
module fba_front #(
  parameter int MAX_RUN = 64,
  parameter int FW      = 17
) (
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    in_op,
  input  logic [fba_pkg::FRAME_W-1:0]   in_frame_index,
  input  logic [fba_pkg::RUN_W-1:0]     in_run_length,
  input  logic [FW-1:0]                 lim,
  input  logic                          q_full,
  input  fba_pkg::back_stat_t           stat,
  output logic                          push,
  output fba_pkg::cmd_t                 cmd
);

  assign in_ready = !q_full && !stat.clearing;
  assign push     = in_valid && in_ready;

  always_comb begin
    case (in_op)
      fba_pkg::OP_MARK_USED: cmd.kind = fba_pkg::K_MARK_USED;
      fba_pkg::OP_MARK_FREE: cmd.kind = fba_pkg::K_MARK_FREE;
      fba_pkg::OP_TEST:      cmd.kind = fba_pkg::K_TEST;
      fba_pkg::OP_ALLOC_ONE: cmd.kind = fba_pkg::K_ALLOC_ONE;
      fba_pkg::OP_ALLOC_RUN: cmd.kind = fba_pkg::K_ALLOC_RUN;
      default:               cmd.kind = fba_pkg::K_NOP;
    endcase
    cmd.frame  = in_frame_index;
    cmd.run    = in_run_length;
    cmd.inr    = 32'(in_frame_index) < 32'(lim);
    cmd.run_ok = (in_run_length != '0) && (32'(in_run_length) <= MAX_RUN);
  end

endmodule

FILE: hw/rtl/fba_queue.sv
`timescale 1ns / 1ps
module fba_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  fba_pkg::cmd_t push_data,
  input  logic          pop,
  output logic          q_valid,
  output logic          q_full,
  output fba_pkg::cmd_t q_data
);

  fba_pkg::cmd_t entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign q_valid = cnt_r != 2'd0;
  assign q_full  = cnt_r == 2'd2;
  assign q_data  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: hw/rtl/fba_back.sv
`timescale 1ns / 1ps
module fba_back #(
  parameter int WORD_BITS = 32,
  parameter int MAX_RUN   = 64,
  parameter int FW        = 17,
  parameter int WORDS     = 2048,
  parameter int AW        = 11,
  parameter int BW        = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [FW-1:0]       lim,
  input  logic                q_valid,
  input  fba_pkg::cmd_t       q_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fba_pkg::res_t       out_res,
  output fba_pkg::back_stat_t stat
);

  localparam int HL = MAX_RUN;
  localparam int VL = HL + WORD_BITS;
  localparam int CW = AW + 1;

  fba_pkg::state_t state_r, state_nxt;
  fba_pkg::cmd_t   cmd_r, cmd_nxt;
  fba_pkg::res_t   res_r, res_nxt;
  logic [CW-1:0]   cur_r, cur_nxt;
  logic            pend_r, pend_nxt;
  logic [AW-1:0]   paddr_r, paddr_nxt;
  logic            pass2_r, pass2_nxt;
  logic [HL-1:0]   hist_r, hist_nxt;
  logic [FW-1:0]   hint_r, hint_nxt;
  logic [FW-1:0]   run_s_r, run_s_nxt;
  logic [FW-1:0]   run_e_r, run_e_nxt;
  logic            out_valid_r, out_valid_nxt;

  logic [WORD_BITS-1:0] mem [WORDS];
  logic [WORD_BITS-1:0] rdata_r;
  logic                 rd_en, wr_en;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  logic                 pop, load;
  logic [CW-1:0]        lim_hi, word_lim;
  logic [BW-1:0]        lim_off;
  logic [WORD_BITS-1:0] inmask, free;
  logic [BW-1:0]        one_b, run_b;
  logic                 one_hit, run_hit, hit, issue, exhausted, retry;
  logic [VL-1:0]        vec, acc, ero;
  logic [WORD_BITS-1:0] hits;
  logic [FW-1:0]        one_frame, run_end, run_start;
  logic [CW-1:0]        s_word, e_word;
  logic [BW-1:0]        bit_off;
  logic [WORD_BITS-1:0] bit_mask, lo_mask, hi_mask;
  logic                 is_run;

  assign lim_off  = lim[BW-1:0];
  assign lim_hi   = CW'(lim >> BW);
  assign word_lim = lim_hi + CW'(lim_off != '0);

  // frames at or above the limit never count as free
  assign inmask = ({1'b0, paddr_r} < lim_hi) ? '1 :
                  ((WORD_BITS'(1) << lim_off) - WORD_BITS'(1));
  assign free   = ~rdata_r & inmask;
  assign is_run = cmd_r.kind == fba_pkg::K_ALLOC_RUN;

  always_comb begin
    one_b = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (free[b]) one_b = BW'(b);
    end
  end
  assign one_hit = |free;

  // run of rl free frames ending at each position, built from doubling windows
  assign vec = {free, hist_r};
  always_comb begin
    acc = '1;
    ero = vec;
    for (int k = 0; k < fba_pkg::RUN_W; k++) begin
      if (cmd_r.run[k]) acc = ero & (acc << (1 << k));
      ero = ero & (ero << (1 << k));
    end
  end
  assign hits = acc[VL-1:HL];

  always_comb begin
    run_b = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (hits[b]) run_b = BW'(b);
    end
  end
  assign run_hit = |hits;

  assign one_frame = FW'({paddr_r, one_b});
  assign run_end   = FW'({paddr_r, run_b});
  assign run_start = run_end + FW'(1) - FW'(cmd_r.run);
  assign s_word    = CW'(run_s_r >> BW);
  assign e_word    = CW'(run_e_r >> BW);

  assign hit       = pend_r && (is_run ? run_hit : one_hit);
  assign issue     = (cur_r < word_lim) && !hit;
  assign exhausted = !pend_r && !(cur_r < word_lim);
  assign retry     = !is_run && !pass2_r && (hint_r != '0);

  assign pop     = (state_r == fba_pkg::ST_IDLE) && q_valid && !out_valid_r;
  assign bit_off = cmd_r.frame[BW-1:0];
  assign bit_mask = WORD_BITS'(1) << bit_off;
  assign lo_mask = (cur_r == s_word) ? ('1 << run_s_r[BW-1:0]) : '1;
  assign hi_mask = (cur_r == e_word) ?
                   ('1 >> (BW'(WORD_BITS - 1) - run_e_r[BW-1:0])) : '1;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fba_pkg::ST_CLEAR: begin
        if (cur_r == CW'(WORDS - 1)) state_nxt = fba_pkg::ST_IDLE;
      end
      fba_pkg::ST_IDLE: begin
        if (pop) begin
          case (q_data.kind)
            fba_pkg::K_MARK_USED, fba_pkg::K_MARK_FREE, fba_pkg::K_TEST: begin
              if (q_data.inr) state_nxt = fba_pkg::ST_BIT;
            end
            fba_pkg::K_ALLOC_ONE: state_nxt = fba_pkg::ST_SCAN;
            fba_pkg::K_ALLOC_RUN: begin
              if (q_data.run_ok) state_nxt = fba_pkg::ST_SCAN;
            end
            default: state_nxt = fba_pkg::ST_IDLE;
          endcase
        end
      end
      fba_pkg::ST_BIT: state_nxt = fba_pkg::ST_IDLE;
      fba_pkg::ST_SCAN: begin
        if (hit) begin
          state_nxt = is_run ? fba_pkg::ST_MARK_RD : fba_pkg::ST_IDLE;
        end else if (exhausted && !retry) begin
          state_nxt = fba_pkg::ST_IDLE;
        end
      end
      fba_pkg::ST_MARK_RD: state_nxt = fba_pkg::ST_MARK_WR;
      fba_pkg::ST_MARK_WR: begin
        if (cur_r == e_word) state_nxt = fba_pkg::ST_IDLE;
        else state_nxt = fba_pkg::ST_MARK_RD;
      end
      default: state_nxt = fba_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cmd_nxt   = cmd_r;
    res_nxt   = res_r;
    cur_nxt   = cur_r;
    pend_nxt  = pend_r;
    paddr_nxt = paddr_r;
    pass2_nxt = pass2_r;
    hist_nxt  = hist_r;
    hint_nxt  = hint_r;
    run_s_nxt = run_s_r;
    run_e_nxt = run_e_r;
    rd_en     = 1'b0;
    rd_addr   = cur_r[AW-1:0];
    wr_en     = 1'b0;
    wr_addr   = cur_r[AW-1:0];
    wr_data   = '0;
    load      = 1'b0;
    case (state_r)
      fba_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        cur_nxt = cur_r + CW'(1);
      end
      fba_pkg::ST_IDLE: begin
        if (pop) begin
          cmd_nxt   = q_data;
          pend_nxt  = 1'b0;
          pass2_nxt = 1'b0;
          hist_nxt  = '0;
          res_nxt   = '0;
          case (q_data.kind)
            fba_pkg::K_MARK_USED, fba_pkg::K_MARK_FREE, fba_pkg::K_TEST: begin
              if (q_data.inr) begin
                rd_en   = 1'b1;
                rd_addr = AW'(q_data.frame >> BW);
              end else begin
                load         = 1'b1;
                res_nxt.used = q_data.kind == fba_pkg::K_TEST;
              end
            end
            fba_pkg::K_ALLOC_ONE: cur_nxt = CW'(hint_r >> BW);
            fba_pkg::K_ALLOC_RUN: begin
              if (q_data.run_ok) begin
                cur_nxt = '0;
              end else begin
                load           = 1'b1;
                res_nxt.failed = 1'b1;
              end
            end
            default: load = 1'b1;
          endcase
        end
      end
      fba_pkg::ST_BIT: begin
        wr_addr = AW'(cmd_r.frame >> BW);
        load    = 1'b1;
        case (cmd_r.kind)
          fba_pkg::K_MARK_USED: begin
            wr_en   = 1'b1;
            wr_data = rdata_r | bit_mask;
          end
          fba_pkg::K_MARK_FREE: begin
            wr_en   = 1'b1;
            wr_data = rdata_r & ~bit_mask;
            if (FW'(cmd_r.frame) < hint_r) hint_nxt = FW'(cmd_r.frame);
          end
          default: res_nxt.used = rdata_r[bit_off];
        endcase
      end
      fba_pkg::ST_SCAN: begin
        // one word read issued per cycle, checked the cycle after
        if (issue) begin
          rd_en     = 1'b1;
          cur_nxt   = cur_r + CW'(1);
          pend_nxt  = 1'b1;
          paddr_nxt = cur_r[AW-1:0];
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r && is_run) hist_nxt = vec[VL-1:WORD_BITS];
        if (hit) begin
          if (is_run) begin
            run_s_nxt = run_start;
            run_e_nxt = run_end;
            cur_nxt   = CW'(run_start >> BW);
          end else begin
            wr_en         = 1'b1;
            wr_addr       = paddr_r;
            wr_data       = rdata_r | (WORD_BITS'(1) << one_b);
            hint_nxt      = one_frame + FW'(1);
            load          = 1'b1;
            res_nxt.frame = fba_pkg::FRAME_W'(one_frame);
          end
        end else if (exhausted) begin
          if (retry) begin
            hint_nxt  = '0;
            pass2_nxt = 1'b1;
            cur_nxt   = '0;
          end else begin
            load           = 1'b1;
            res_nxt.failed = 1'b1;
          end
        end
      end
      fba_pkg::ST_MARK_RD: rd_en = 1'b1;
      fba_pkg::ST_MARK_WR: begin
        wr_en   = 1'b1;
        wr_data = rdata_r | (lo_mask & hi_mask);
        if (cur_r == e_word) begin
          load          = 1'b1;
          res_nxt.frame = fba_pkg::FRAME_W'(run_s_r);
        end else begin
          cur_nxt = cur_r + CW'(1);
        end
      end
      default: load = 1'b0;
    endcase
    out_valid_nxt = (out_valid_r && !out_ready) || load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fba_pkg::ST_CLEAR;
      cur_r       <= '0;
      pend_r      <= 1'b0;
      pass2_r     <= 1'b0;
      hint_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      pend_r      <= pend_nxt;
      pass2_r     <= pass2_nxt;
      hint_r      <= hint_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    res_r   <= res_nxt;
    paddr_r <= paddr_nxt;
    hist_r  <= hist_nxt;
    run_s_r <= run_s_nxt;
    run_e_r <= run_e_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_r <= mem[rd_addr];
  end

  assign out_valid     = out_valid_r;
  assign out_res       = res_r;
  assign stat.clearing = state_r == fba_pkg::ST_CLEAR;
  assign stat.pop      = pop;

endmodule

FILE: hw/rtl/frame_bitmap_allocator.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready  | in_op, in_frame_index, in_run_length
// out     | output    | out_valid / out_ready| out_result_frame, out_frame_used, out_failed
// cfg     | input     | APB, cfg_pready = 1  | frame_count at byte address 0
//
// mark_used, mark_free, test: a memory read, then a write-back for the two marks only.
// alloc_one: scans words from the hint, with a second pass from word 0 if the first finds none;
//   the single-port bitmap memory streams one word per cycle.
// alloc_run: scans from word 0, then reads and writes back each word of the run.
// After reset a clearing pass zeros every bitmap word; no item
//   is accepted during it. A 2-entry queue keeps taking items while a result stalls.
`include "frame_bitmap_allocator_defines.svh"
module frame_bitmap_allocator #(
  parameter int MAX_FRAMES = 65536,
  parameter int WORD_BITS  = 32,
  parameter int MAX_RUN    = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  in_op,
  input  logic [fba_pkg::FRAME_W-1:0] in_frame_index,
  input  logic [fba_pkg::RUN_W-1:0]   in_run_length,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [fba_pkg::FRAME_W-1:0] out_result_frame,
  output logic                        out_frame_used,
  output logic                        out_failed,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [2:0]                  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  localparam int FW    = $clog2(MAX_FRAMES + 1);
  localparam int WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int BW    = $clog2(WORD_BITS);

  logic [fba_pkg::CNT_W-1:0] frame_count_r, frame_count_nxt;
  logic [FW-1:0]             lim;
  logic                      push, q_valid, q_full;
  fba_pkg::cmd_t             push_cmd, q_data;
  fba_pkg::res_t             res;
  fba_pkg::back_stat_t       stat;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == fba_pkg::REG_FRAME_COUNT) ? 32'(frame_count_r) : '0;

  always_comb begin
    frame_count_nxt = frame_count_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
        cfg_paddr[2] == fba_pkg::REG_FRAME_COUNT) begin
      frame_count_nxt = cfg_pwdata[fba_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) frame_count_r <= fba_pkg::CNT_W'(MAX_FRAMES);
    else frame_count_r <= frame_count_nxt;
  end

  // counts above the bitmap size act as the bitmap size
  assign lim = (32'(frame_count_r) > 32'(MAX_FRAMES)) ? FW'(MAX_FRAMES) : FW'(frame_count_r);

  fba_front #(
    .MAX_RUN (MAX_RUN),
    .FW      (FW)
  ) u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_frame_index (in_frame_index),
    .in_run_length  (in_run_length),
    .lim            (lim),
    .q_full         (q_full),
    .stat           (stat),
    .push           (push),
    .cmd            (push_cmd)
  );

  fba_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_cmd),
    .pop       (stat.pop),
    .q_valid   (q_valid),
    .q_full    (q_full),
    .q_data    (q_data)
  );

  fba_back #(
    .WORD_BITS (WORD_BITS),
    .MAX_RUN   (MAX_RUN),
    .FW        (FW),
    .WORDS     (WORDS),
    .AW        (AW),
    .BW        (BW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .lim       (lim),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res),
    .stat      (stat)
  );

  assign out_result_frame = res.frame;
  assign out_frame_used   = res.used;
  assign out_failed       = res.failed;

  `FBA_ASSERT_IMP(a_no_accept_clear, clk, rst_n, stat.clearing, !in_ready)
  `FBA_ASSERT_IMP(a_pop_out_empty, clk, rst_n, stat.pop, !out_valid)
  `FBA_ASSERT_IMP(a_fail_clean, clk, rst_n, out_valid && out_failed, (out_result_frame == '0) && !out_frame_used)
  `FBA_ASSERT_NXT(a_pop_when_valid, clk, rst_n, stat.pop && !push && q_full, !q_full)

endmodule
